// ----- src/awo_pkg.sv -----
// Package for the additive waveform oscillator: sizes, constants, codes and state type.
package awo_pkg;

   localparam int MAX_HARMONICS   = 32;
   localparam int BLOCK_FRAMES    = 512;
   localparam int SINE_TABLE_BITS = 10;

   localparam int PHASE_W = 32;
   localparam int MODE_W  = 2;
   localparam int HC_W    = 6;
   localparam int VOL_W   = 16;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 2;
   localparam int SMP_W   = 16;

   localparam int BPOS_W = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
   localparam int N_W    = $clog2(2 * MAX_HARMONICS);
   localparam int TERM_W = $clog2(MAX_HARMONICS + 1);

   localparam int MUL_AW = 24;
   localparam int MUL_BW = 17;
   localparam int MUL_PW = MUL_AW + MUL_BW;

   localparam int Z_W     = 17;
   localparam int Y_W     = 15;
   localparam int DIV_NW  = Y_W + 16;
   localparam int DIV_CW  = $clog2(DIV_NW);
   localparam int ACC_W   = 36;
   localparam int SMAG_W  = 21;
   localparam int GL_W    = 46;
   localparam int GN_W    = 52;

   localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SAW    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [IDX_W-1:0] REG_INC    = 2'd1;
   localparam logic [IDX_W-1:0] REG_HCOUNT = 2'd2;
   localparam logic [IDX_W-1:0] REG_VOLUME = 2'd3;

   localparam logic [HC_W-1:0]  HCOUNT_RST = 6'd10;
   localparam logic [VOL_W-1:0] VOLUME_RST = 16'd3277;
   localparam logic [MUL_BW-1:0] VOL_ONE   = 17'd32768;

   localparam logic [MUL_BW-1:0] GLIDE_COEF  = 17'd3277;
   localparam logic [MUL_BW-1:0] GAIN_SQUARE = 17'd41722;
   localparam logic [MUL_BW-1:0] GAIN_SAW    = 17'd20861;
   localparam logic [MUL_AW-1:0] SIN_A       = 24'd51472;
   localparam logic [MUL_AW-1:0] SIN_B       = 24'd21024;
   localparam logic [MUL_AW-1:0] SIN_C       = 24'd2320;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GL1,
      ST_GL2,
      ST_GL3,
      ST_ADV,
      ST_HSET,
      ST_HLOOP,
      ST_SIN0,
      ST_SIN1,
      ST_SIN2,
      ST_SIN3,
      ST_SIN4,
      ST_SIN5,
      ST_DIVS,
      ST_DIVW,
      ST_GN1,
      ST_GN2,
      ST_GN3,
      ST_VOL1,
      ST_VOL2,
      ST_OUT
   } state_type;

endpackage

// ----- src/awo_mul.sv -----
// Shared unsigned multiplier with registered product.
module awo_mul (
   input  logic                             clock,
   input  logic [awo_pkg::MUL_AW-1:0]       mul_a,
   input  logic [awo_pkg::MUL_BW-1:0]       mul_b,
   output logic [awo_pkg::MUL_PW-1:0]       mul_p
);

   logic [awo_pkg::MUL_PW-1:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= awo_pkg::MUL_PW'(mul_a) * awo_pkg::MUL_PW'(mul_b);
   end

   assign mul_p = p_ff;

endmodule

// ----- src/awo_div.sv -----
// Bit-serial restoring divider for the harmonic term scaling.
module awo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [awo_pkg::DIV_NW-1:0]    dividend,
   input  logic [awo_pkg::N_W-1:0]       divisor,
   output logic                          done,
   output logic [awo_pkg::DIV_NW-1:0]    quotient
);

   localparam logic [awo_pkg::DIV_CW-1:0] LAST = awo_pkg::DIV_CW'(awo_pkg::DIV_NW - 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [awo_pkg::DIV_CW-1:0]  cnt_ff, cnt_in;
   logic [awo_pkg::N_W-1:0]     rem_ff, rem_in;
   logic [awo_pkg::N_W-1:0]     dvs_ff, dvs_in;
   logic [awo_pkg::DIV_NW-1:0]  quo_ff, quo_in;
   logic [awo_pkg::N_W:0]       rs;
   logic                        ge;

   always_comb begin
      rs      = {rem_ff, quo_ff[awo_pkg::DIV_NW-1]};
      ge      = rs >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? awo_pkg::N_W'(rs - {1'b0, dvs_ff}) : awo_pkg::N_W'(rs);
         quo_in = {quo_ff[awo_pkg::DIV_NW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/additive_waveform_oscillator_core.sv -----
// Top level of the additive waveform oscillator: sequencer, state and registers.
//
// req_ channel: one beat asks for one sample (req_sample_tick = 1); a beat
// with the tick low is taken and dropped. rsp_ channel: one beat per
// sample, rsp_sample_out in Q1.15. csr_ port: write enable, index, data.
// In sine mode the glide is updated at the start of each block before the
// phase advances. Square and sawtooth modes sum harmonic terms (H terms
// for square, H-1 for sawtooth), each scaled by the bit-serial divider;
// every multiply goes through the one shared multiplier.
// req_ready is high only while the sequencer is idle. The result sits in
// an output register, so a new request is taken while it waits; a second
// result waits in the sequencer until the first beat has gone.
// Reset (synchronous) clears the phases, glide and block position, loads
// the register defaults and drops any pending result.
module additive_waveform_oscillator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_sample_tick,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [awo_pkg::SMP_W-1:0]  rsp_sample_out,
   input  logic                              csr_we,
   input  logic [awo_pkg::IDX_W-1:0]         csr_index,
   input  logic [awo_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int PW = awo_pkg::PHASE_W;
   localparam int STB = awo_pkg::SINE_TABLE_BITS;

   awo_pkg::state_type state_ff, state_in;

   logic [awo_pkg::MODE_W-1:0] mode_ff;
   logic [PW-1:0]              inc_ff;
   logic [awo_pkg::HC_W-1:0]   hcount_ff;
   logic [awo_pkg::VOL_W-1:0]  vol_ff;

   logic [PW-1:0]              phase_ff, phase_in;
   logic [PW-1:0]              glide_ff, glide_in;
   logic [awo_pkg::BPOS_W-1:0] bpos_ff, bpos_in;
   logic [PW-1:0]              htp_ff, htp_in;

   logic [PW-1:0]                  ang_ff, ang_in;
   logic [PW-1:0]                  step_ff, step_in;
   logic [awo_pkg::N_W-1:0]        n_ff, n_in;
   logic [awo_pkg::TERM_W-1:0]     terms_ff, terms_in;
   logic signed [awo_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [awo_pkg::Z_W-1:0]        z_ff, z_in;
   logic [awo_pkg::Z_W-1:0]        z2_ff, z2_in;
   logic                           neg_ff, neg_in;
   logic [awo_pkg::Y_W-1:0]        y_ff, y_in;
   logic [awo_pkg::SMAG_W-1:0]     smag_ff, smag_in;
   logic                           sneg_ff, sneg_in;
   logic [awo_pkg::MUL_PW-1:0]     pl_ff, pl_in;
   logic [awo_pkg::SMP_W-1:0]      res_ff, res_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [awo_pkg::SMP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic [awo_pkg::MUL_AW-1:0] mul_a;
   logic [awo_pkg::MUL_BW-1:0] mul_b;
   logic [awo_pkg::MUL_PW-1:0] mul_p;
   logic                       div_start, div_done;
   logic [awo_pkg::DIV_NW-1:0] div_q;

   logic       accept, harm, saw, out_free;
   logic [PW:0] d, dmag;
   logic [awo_pkg::GL_W-1:0] gl_tot, gl_delta;
   logic [awo_pkg::GN_W-1:0] gn_tot;
   logic [awo_pkg::ACC_W-1:0] amag;
   logic [PW-1:0] a_ang, u_ang;
   logic [awo_pkg::MUL_PW-16:0] r;
   logic [awo_pkg::Z_W-1:0] yv, m;
   logic [awo_pkg::MUL_BW-1:0] vol_sat;
   logic [awo_pkg::HC_W:0] h;
   logic [awo_pkg::BPOS_W:0] bpos_nx;
   logic [PW-1:0] phase_nx;

   assign accept   = req_valid && req_ready;
   assign harm     = (mode_ff == awo_pkg::MODE_SQUARE) || (mode_ff == awo_pkg::MODE_SAW);
   assign saw      = mode_ff == awo_pkg::MODE_SAW;
   assign out_free = !rsp_valid_ff || rsp_ready;

   awo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   awo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({y_ff, 16'd0}),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         awo_pkg::ST_IDLE: begin
            if (accept && req_sample_tick) begin
               if (harm)
                  state_in = awo_pkg::ST_HSET;
               else if (bpos_ff == '0)
                  state_in = awo_pkg::ST_GL1;
               else
                  state_in = awo_pkg::ST_ADV;
            end
         end
         awo_pkg::ST_GL1:   state_in = awo_pkg::ST_GL2;
         awo_pkg::ST_GL2:   state_in = awo_pkg::ST_GL3;
         awo_pkg::ST_GL3:   state_in = awo_pkg::ST_ADV;
         awo_pkg::ST_ADV:   state_in = awo_pkg::ST_SIN0;
         awo_pkg::ST_HSET:  state_in = awo_pkg::ST_HLOOP;
         awo_pkg::ST_HLOOP: state_in = (terms_ff == '0) ? awo_pkg::ST_GN1 : awo_pkg::ST_SIN0;
         awo_pkg::ST_SIN0:  state_in = awo_pkg::ST_SIN1;
         awo_pkg::ST_SIN1:  state_in = awo_pkg::ST_SIN2;
         awo_pkg::ST_SIN2:  state_in = awo_pkg::ST_SIN3;
         awo_pkg::ST_SIN3:  state_in = awo_pkg::ST_SIN4;
         awo_pkg::ST_SIN4:  state_in = awo_pkg::ST_SIN5;
         awo_pkg::ST_SIN5:  state_in = harm ? awo_pkg::ST_DIVS : awo_pkg::ST_VOL1;
         awo_pkg::ST_DIVS:  state_in = awo_pkg::ST_DIVW;
         awo_pkg::ST_DIVW:  state_in = div_done ? awo_pkg::ST_HLOOP : awo_pkg::ST_DIVW;
         awo_pkg::ST_GN1:   state_in = awo_pkg::ST_GN2;
         awo_pkg::ST_GN2:   state_in = awo_pkg::ST_GN3;
         awo_pkg::ST_GN3:   state_in = awo_pkg::ST_VOL1;
         awo_pkg::ST_VOL1:  state_in = awo_pkg::ST_VOL2;
         awo_pkg::ST_VOL2:  state_in = awo_pkg::ST_OUT;
         awo_pkg::ST_OUT:   state_in = out_free ? awo_pkg::ST_IDLE : awo_pkg::ST_OUT;
         default:           state_in = awo_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      d        = {1'b0, inc_ff} - {1'b0, glide_ff};
      dmag     = d[PW] ? (~d + 1'b1) : d;
      gl_tot   = (awo_pkg::GL_W'(mul_p) << 17) + awo_pkg::GL_W'(pl_ff);
      gl_delta = d[PW] ? ((gl_tot + awo_pkg::GL_W'(65535)) >> 16) : (gl_tot >> 16);
      gn_tot   = (awo_pkg::GN_W'(mul_p) << 17) + awo_pkg::GN_W'(pl_ff);
      amag     = acc_ff[awo_pkg::ACC_W-1] ? awo_pkg::ACC_W'(-acc_ff) : awo_pkg::ACC_W'(acc_ff);
      a_ang    = {ang_ff[PW-1 -: STB], {(PW-STB){1'b0}}};
      u_ang    = {1'b0, a_ang[PW-2:0]};
      if (u_ang > 32'h4000_0000)
         u_ang = 32'h8000_0000 - u_ang;
      r        = mul_p[awo_pkg::MUL_PW-1:15];
      yv       = mul_p[31:15];
      m        = (r > 26'd32768) ? 17'd32768 : r[awo_pkg::Z_W-1:0];
      vol_sat  = ({1'b0, vol_ff} > awo_pkg::VOL_ONE) ? awo_pkg::VOL_ONE : {1'b0, vol_ff};
      h        = ({1'b0, hcount_ff} > 7'(awo_pkg::MAX_HARMONICS)) ?
                 7'(awo_pkg::MAX_HARMONICS) : {1'b0, hcount_ff};
      bpos_nx  = {1'b0, bpos_ff} + 1'b1;
      phase_nx = phase_ff + glide_ff;

      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      phase_in  = phase_ff;
      glide_in  = glide_ff;
      bpos_in   = bpos_ff;
      htp_in    = htp_ff;
      ang_in    = ang_ff;
      step_in   = step_ff;
      n_in      = n_ff;
      terms_in  = terms_ff;
      acc_in    = acc_ff;
      z_in      = z_ff;
      z2_in     = z2_ff;
      neg_in    = neg_ff;
      y_in      = y_ff;
      smag_in   = smag_ff;
      sneg_in   = sneg_ff;
      pl_in     = pl_ff;
      res_in    = res_ff;

      unique case (state_ff)
         awo_pkg::ST_GL1: begin
            mul_a = awo_pkg::MUL_AW'(dmag[16:0]);
            mul_b = awo_pkg::GLIDE_COEF;
         end
         awo_pkg::ST_GL2: begin
            pl_in = mul_p;
            mul_a = awo_pkg::MUL_AW'(dmag[PW:17]);
            mul_b = awo_pkg::GLIDE_COEF;
         end
         awo_pkg::ST_GL3: begin
            glide_in = d[PW] ? glide_ff - gl_delta[PW-1:0] : glide_ff + gl_delta[PW-1:0];
         end
         awo_pkg::ST_ADV: begin
            bpos_in  = (bpos_nx >= (awo_pkg::BPOS_W+1)'(awo_pkg::BLOCK_FRAMES)) ?
                       '0 : bpos_nx[awo_pkg::BPOS_W-1:0];
            phase_in = phase_nx;
            ang_in   = phase_nx;
         end
         awo_pkg::ST_HSET: begin
            ang_in   = htp_ff;
            step_in  = saw ? htp_ff : {htp_ff[PW-2:0], 1'b0};
            n_in     = awo_pkg::N_W'(1);
            acc_in   = '0;
            htp_in   = htp_ff + inc_ff;
            if (!saw)
               terms_in = awo_pkg::TERM_W'(h);
            else
               terms_in = (h > 7'd1) ? awo_pkg::TERM_W'(h - 7'd1) : '0;
         end
         awo_pkg::ST_SIN0: begin
            neg_in = a_ang[PW-1];
            z_in   = u_ang[31:15];
         end
         awo_pkg::ST_SIN1: begin
            mul_a = awo_pkg::MUL_AW'(z_ff);
            mul_b = z_ff;
         end
         awo_pkg::ST_SIN2: begin
            z2_in = yv;
            mul_a = awo_pkg::SIN_C;
            mul_b = yv;
         end
         awo_pkg::ST_SIN3: begin
            mul_a = awo_pkg::SIN_B - awo_pkg::MUL_AW'(yv);
            mul_b = z2_ff;
         end
         awo_pkg::ST_SIN4: begin
            mul_a = awo_pkg::SIN_A - awo_pkg::MUL_AW'(yv);
            mul_b = z_ff;
         end
         awo_pkg::ST_SIN5: begin
            y_in    = (yv > 17'd32767) ? 15'h7fff : yv[awo_pkg::Y_W-1:0];
            smag_in = (yv > 17'd32767) ? awo_pkg::SMAG_W'(32767) : awo_pkg::SMAG_W'(yv);
            sneg_in = neg_ff;
         end
         awo_pkg::ST_DIVS: begin
            div_start = 1'b1;
         end
         awo_pkg::ST_DIVW: begin
            if (div_done) begin
               if (neg_ff ^ (saw & n_ff[0]))
                  acc_in = acc_ff - $signed(awo_pkg::ACC_W'(div_q));
               else
                  acc_in = acc_ff + $signed(awo_pkg::ACC_W'(div_q));
               n_in     = saw ? n_ff + 1'b1 : n_ff + 2'd2;
               ang_in   = ang_ff + step_ff;
               terms_in = terms_ff - 1'b1;
            end
         end
         awo_pkg::ST_GN1: begin
            mul_a = awo_pkg::MUL_AW'(amag[16:0]);
            mul_b = saw ? awo_pkg::GAIN_SAW : awo_pkg::GAIN_SQUARE;
         end
         awo_pkg::ST_GN2: begin
            pl_in = mul_p;
            mul_a = awo_pkg::MUL_AW'(amag[34:17]);
            mul_b = saw ? awo_pkg::GAIN_SAW : awo_pkg::GAIN_SQUARE;
         end
         awo_pkg::ST_GN3: begin
            smag_in = gn_tot[awo_pkg::GN_W-1:31];
            sneg_in = acc_ff[awo_pkg::ACC_W-1];
         end
         awo_pkg::ST_VOL1: begin
            mul_a = awo_pkg::MUL_AW'(smag_ff);
            mul_b = vol_sat;
         end
         awo_pkg::ST_VOL2: begin
            if (!sneg_ff)
               res_in = (r > 26'd32767) ? 16'h7fff : r[awo_pkg::SMP_W-1:0];
            else
               res_in = awo_pkg::SMP_W'(17'd0 - m);
         end
         default: begin
         end
      endcase

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == awo_pkg::ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= awo_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= awo_pkg::MODE_SINE;
         inc_ff       <= '0;
         hcount_ff    <= awo_pkg::HCOUNT_RST;
         vol_ff       <= awo_pkg::VOLUME_RST;
         phase_ff     <= '0;
         glide_ff     <= '0;
         bpos_ff      <= '0;
         htp_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         glide_ff     <= glide_in;
         bpos_ff      <= bpos_in;
         htp_ff       <= htp_in;
         if (csr_we) begin
            unique case (csr_index)
               awo_pkg::REG_MODE:   mode_ff   <= csr_wdata[awo_pkg::MODE_W-1:0];
               awo_pkg::REG_INC:    inc_ff    <= csr_wdata[PW-1:0];
               awo_pkg::REG_HCOUNT: hcount_ff <= csr_wdata[awo_pkg::HC_W-1:0];
               awo_pkg::REG_VOLUME: vol_ff    <= csr_wdata[awo_pkg::VOL_W-1:0];
               default: begin
               end
            endcase
         end
      end
      ang_ff      <= ang_in;
      step_ff     <= step_in;
      n_ff        <= n_in;
      terms_ff    <= terms_in;
      acc_ff      <= acc_in;
      z_ff        <= z_in;
      z2_ff       <= z2_in;
      neg_ff      <= neg_in;
      y_ff        <= y_in;
      smag_ff     <= smag_in;
      sneg_ff     <= sneg_in;
      pl_ff       <= pl_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready      = state_ff == awo_pkg::ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = $signed(rsp_data_ff);

endmodule

// ----- src/awo_checker.sv -----
// Port-level checks for the oscillator core, bound to the top level.
module awo_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_sample_tick,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [awo_pkg::SMP_W-1:0]  rsp_sample_out
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result beat changed while stalled");

   // a tick beat keeps the sequencer busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_sample_tick |=> !req_ready)
      else $error("request taken while sample in progress");

   // a dropped tick leaves the block ready and makes no result
   a_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_sample_tick && !rsp_valid |=> req_ready && !rsp_valid)
      else $error("empty tick produced work");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending after reset");

endmodule

bind additive_waveform_oscillator_core awo_checker u_awo_checker (.*);

// ----- dv/additive_waveform_oscillator_core_tb.sv -----
// Self-checking testbench for the additive waveform oscillator core.
module additive_waveform_oscillator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int N_ITEMS        = 1400;

   typedef struct packed {
      logic                              load;
      logic [awo_pkg::MODE_W-1:0]        mode;
      logic [awo_pkg::PHASE_W-1:0]       inc;
      logic [awo_pkg::HC_W-1:0]          hcount;
      logic [awo_pkg::VOL_W-1:0]         vol;
      logic                              tick;
      logic                              known;
      logic [awo_pkg::SMP_W-1:0]         sample;
   } stim_row_type;

   localparam int N_DIRECTED = 19;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b1, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b0, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_SINE,   32'h4000_0000, 6'd10, 16'd32768, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_SQUARE, 32'h4000_0000, 6'd0,  16'd32768, 1'b1, 1'b1, 16'd0},
      '{1'b1, awo_pkg::MODE_SQUARE, 32'h4000_0000, 6'd1,  16'd65535, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_SAW,    32'h4000_0000, 6'd1,  16'd32768, 1'b1, 1'b1, 16'd0},
      '{1'b1, awo_pkg::MODE_SAW,    32'hFFFF_FFFF, 6'd63, 16'd32768, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 6'd32, 16'd0,     1'b1, 1'b1, 16'd0},
      '{1'b1, awo_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 6'd32, 16'd32768, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_SQUARE, 32'h1234_5678, 6'd32, 16'd20000, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b0, 1'b0, 16'd0},
      '{1'b1, awo_pkg::MODE_SINE,   32'h0,         6'd5,  16'd65535, 1'b1, 1'b0, 16'd0},
      '{1'b0, awo_pkg::MODE_SINE,   32'h0,         6'd0,  16'd0,     1'b1, 1'b0, 16'd0}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic                              req_sample_tick;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic signed [awo_pkg::SMP_W-1:0]  rsp_sample_out;
   logic                              csr_we;
   logic [awo_pkg::IDX_W-1:0]         csr_index;
   logic [awo_pkg::DATA_W-1:0]        csr_wdata;

   additive_waveform_oscillator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_tick(req_sample_tick),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // oscillator registers and state as the predictor sees them
   logic [awo_pkg::MODE_W-1:0]  osc_mode;
   logic [awo_pkg::PHASE_W-1:0] osc_target_inc;
   logic [awo_pkg::HC_W-1:0]    osc_hcount;
   logic [awo_pkg::VOL_W-1:0]   osc_volume;
   logic [31:0]                 osc_sine_phase;
   logic [31:0]                 osc_glide_inc;
   int unsigned                 osc_block_pos;
   logic [31:0]                 osc_harm_phase;

   logic signed [awo_pkg::SMP_W-1:0] pending_samples [$];
   int unsigned mismatches;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned items_sent;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint sine_q15(input logic [31:0] angle);
      logic [31:0] a;
      logic [31:0] u;
      longint z, z2, t, y;
      a = angle & ~((32'd1 << (32 - awo_pkg::SINE_TABLE_BITS)) - 32'd1);
      u = a & 32'h7FFF_FFFF;
      if (u > 32'h4000_0000) u = 32'h8000_0000 - u;
      z  = longint'(u >> 15);
      z2 = (z * z) >> 15;
      t  = (2320 * z2) >> 15;
      t  = ((21024 - t) * z2) >> 15;
      y  = ((51472 - t) * z) >> 15;
      if (y > 32767) y = 32767;
      return a[31] ? -y : y;
   endfunction

   function automatic logic signed [awo_pkg::SMP_W-1:0] scale_by_volume(input longint s);
      longint v, r;
      v = (osc_volume > 16'd32768) ? 32768 : longint'(osc_volume);
      r = (s * v) / 32768;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return awo_pkg::SMP_W'(r);
   endfunction

   function automatic logic signed [awo_pkg::SMP_W-1:0] harmonic_sample(input logic saw);
      int unsigned h;
      longint acc, term;
      logic [31:0] n;
      h = (osc_hcount > awo_pkg::MAX_HARMONICS) ? awo_pkg::MAX_HARMONICS : osc_hcount;
      acc = 0;
      if (!saw) begin
         for (int unsigned k = 0; k < h; k++) begin
            n = 2 * k + 1;
            acc += (sine_q15(n * osc_harm_phase) * 65536) / longint'(n);
         end
         acc = (acc * 41722) / (longint'(1) << 31);
      end else begin
         for (int unsigned k = 1; k < h; k++) begin
            n = k;
            term = (sine_q15(n * osc_harm_phase) * 65536) / longint'(n);
            acc += k[0] ? -term : term;
         end
         acc = (acc * 20861) / (longint'(1) << 31);
      end
      osc_harm_phase = osc_harm_phase + osc_target_inc;
      return scale_by_volume(acc);
   endfunction

   function automatic logic signed [awo_pkg::SMP_W-1:0] gliding_sine_sample();
      longint d;
      if (osc_block_pos == 0) begin
         d = longint'(osc_target_inc) - longint'(osc_glide_inc);
         osc_glide_inc = 32'(longint'(osc_glide_inc) + ((d * 3277) >>> 16));
      end
      osc_block_pos = (osc_block_pos + 1 >= awo_pkg::BLOCK_FRAMES) ? 0 : osc_block_pos + 1;
      osc_sine_phase = osc_sine_phase + osc_glide_inc;
      return scale_by_volume(sine_q15(osc_sine_phase));
   endfunction

   function automatic logic signed [awo_pkg::SMP_W-1:0] next_sample();
      if (osc_mode == awo_pkg::MODE_SQUARE) return harmonic_sample(1'b0);
      if (osc_mode == awo_pkg::MODE_SAW) return harmonic_sample(1'b1);
      return gliding_sine_sample();
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // result side: check each beat and stall on a pattern of its own
   int unsigned stall_phase;
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_samples.size() == 0)
            report_mismatch("unexpected sample", rsp_sample_out, 0);
         else if (rsp_sample_out !== pending_samples[0]) begin
            report_mismatch("sample_out", rsp_sample_out, pending_samples[0]);
            void'(pending_samples.pop_front());
         end else
            void'(pending_samples.pop_front());
      end
      stall_phase <= stall_phase + 1;
      case ((stall_phase >> 7) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_phase[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_beat(input logic tick, input logic known,
                            input logic [awo_pkg::SMP_W-1:0] val);
      logic signed [awo_pkg::SMP_W-1:0] predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_tick <= tick;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (tick) begin
         predicted = next_sample();
         pending_samples.push_back(known ? val : predicted);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(input logic [awo_pkg::MODE_W-1:0] mode,
                                 input logic [awo_pkg::PHASE_W-1:0] inc,
                                 input logic [awo_pkg::HC_W-1:0] hc,
                                 input logic [awo_pkg::VOL_W-1:0] vol);
      drain();
      csr_we <= 1'b1;
      csr_index <= awo_pkg::REG_MODE;
      csr_wdata <= awo_pkg::DATA_W'(mode);
      @(posedge clock);
      csr_index <= awo_pkg::REG_INC;
      csr_wdata <= awo_pkg::DATA_W'(inc);
      @(posedge clock);
      csr_index <= awo_pkg::REG_HCOUNT;
      csr_wdata <= awo_pkg::DATA_W'(hc);
      @(posedge clock);
      csr_index <= awo_pkg::REG_VOLUME;
      csr_wdata <= awo_pkg::DATA_W'(vol);
      @(posedge clock);
      csr_we <= 1'b0;
      osc_mode = mode;
      osc_target_inc = inc;
      osc_hcount = hc;
      osc_volume = vol;
   endtask

   initial begin
      logic [awo_pkg::MODE_W-1:0]  r_mode;
      logic [awo_pkg::PHASE_W-1:0] r_inc;
      logic [awo_pkg::HC_W-1:0]    r_hc;
      logic [awo_pkg::VOL_W-1:0]   r_vol;
      int unsigned                 run_len;
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_tick = 1'b0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_phase = 0;
      mismatches = 0;
      idle_cycles = 0;
      burst_left = 0;
      items_sent = 0;
      osc_mode = awo_pkg::MODE_SINE;
      osc_target_inc = '0;
      osc_hcount = awo_pkg::HCOUNT_RST;
      osc_volume = awo_pkg::VOLUME_RST;
      osc_sine_phase = '0;
      osc_glide_inc = '0;
      osc_block_pos = 0;
      osc_harm_phase = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].load)
            load_registers(DIRECTED[i].mode, DIRECTED[i].inc, DIRECTED[i].hcount,
                           DIRECTED[i].vol);
         send_beat(DIRECTED[i].tick, DIRECTED[i].known, DIRECTED[i].sample);
      end

      while (items_sent < N_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: r_mode = awo_pkg::MODE_SINE;
            5, 6:          r_mode = awo_pkg::MODE_SQUARE;
            7, 8:          r_mode = awo_pkg::MODE_SAW;
            default:       r_mode = awo_pkg::MODE_UNUSED;
         endcase
         case ($urandom_range(0, 4))
            0:       r_inc = $urandom;
            1:       r_inc = $urandom_range(0, 32'h00FF_FFFF);
            2:       r_inc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: r_inc = $urandom_range(32'h0010_0000, 32'h1000_0000);
         endcase
         r_hc = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(32, 63))
                                           : 6'($urandom_range(0, 7));
         case ($urandom_range(0, 3))
            0:       r_vol = awo_pkg::VOL_W'($urandom);
            1:       r_vol = $urandom_range(0, 1) ? 16'd32768 : 16'hFFFF;
            default: r_vol = awo_pkg::VOL_W'($urandom_range(0, 32768));
         endcase
         load_registers(r_mode, r_inc, r_hc, r_vol);
         if (r_mode == awo_pkg::MODE_SQUARE || r_mode == awo_pkg::MODE_SAW)
            run_len = (r_hc >= 32) ? $urandom_range(2, 6) : $urandom_range(10, 40);
         else
            run_len = $urandom_range(30, 200);
         repeat (run_len)
            if (items_sent < N_ITEMS)
               send_beat($urandom_range(0, 9) != 0, 1'b0, '0);
      end

      drain();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

// ----- sim.f -----
src/awo_pkg.sv
src/awo_mul.sv
src/awo_div.sv
src/additive_waveform_oscillator_core.sv
src/awo_checker.sv
dv/additive_waveform_oscillator_core_tb.sv
